// File: rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the DFS topological sorter
// Holds the vertex, count and row types, plus the control word that passes from
// the top level to the search engine and the stack entry layout that it uses.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int ROW_LIMIT        = 16;  // hardware ceiling on vertices
  localparam int VIDX_W           = 4;   // vertex index width
  localparam int CNT_W            = 5;   // count width, holds 0 .. ROW_LIMIT
  localparam int ROW_W            = 16;  // adjacency row width
  localparam int MAX_VERTICES_DEF = 16;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ROW_W-1:0]  row_t;

  // Start request from the loader to the search engine.
  typedef struct packed {
    logic start;
    cnt_t count;
  } dts_ctl_t;

  // One suspended frame of the depth-first walk.
  typedef struct packed {
    vidx_t u;
    cnt_t  next_v;
  } stack_ent_t;

endpackage

// File: rtl/dts_adj.sv
// ----------------------------------------------------------------------------
// dts_adj: adjacency row store
// One row per vertex, written during loading. The search engine addresses it
// with the vertex it moves to, and the registered row follows in the next cycle.
// ----------------------------------------------------------------------------
module dts_adj
  import dts_pkg::*;
#(
  parameter int HARD_ROWS = ROW_LIMIT,
  localparam int AW = (HARD_ROWS > 1) ? $clog2(HARD_ROWS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  row_t          wr_row,
  input  logic [AW-1:0] rd_addr,
  output row_t          rd_row
);

  row_t rows_r [HARD_ROWS];
  row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows_r[wr_addr] <= wr_row;
    end
    rd_row_r <= rows_r[rd_addr];
  end

  assign rd_row = rd_row_r;

endmodule

// File: rtl/dts_dfs.sv
// ----------------------------------------------------------------------------
// dts_dfs: depth-first search engine and result sequencer
// Walks the graph one neighbor test per cycle with an explicit stack, records
// finish order, then streams vertices out in reverse finish order.
// ----------------------------------------------------------------------------
module dts_dfs
  import dts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dts_ctl_t ctl,
  output logic     busy,
  output vidx_t    adj_rd_idx,
  input  row_t     adj_rd_row,
  output logic     out_valid,
  input  logic     out_stall,
  output cnt_t     out_vertex,
  output logic     out_last
);

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_WALK, S_EMIT} state_t;

  state_t     state_r, state_nxt;
  cnt_t       n_r, n_nxt;
  cnt_t       root_r, root_nxt;
  cnt_t       done_r, done_nxt;
  vidx_t      cur_u_r, cur_u_nxt;
  cnt_t       cur_v_r, cur_v_nxt;
  vidx_t      sp_r, sp_nxt;
  row_t       visited_r, visited_nxt;
  vidx_t      emit_idx_r, emit_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  cnt_t       out_vertex_r;
  logic       out_last_r, out_last_nxt;
  stack_ent_t below_r;

  stack_ent_t stack_r [ROW_LIMIT];
  vidx_t      finish_r [ROW_LIMIT];

  logic       push_en, fin_en;
  logic       word_load;
  vidx_t      word_idx;
  vidx_t      test_idx;
  logic       hit;
  stack_ent_t push_ent;
  logic       out_take;

  // The row store is addressed with the next vertex, so its registered row
  // always belongs to cur_u_r.
  assign test_idx   = cur_v_r[VIDX_W-1:0];
  assign adj_rd_idx = cur_u_nxt;
  assign hit        = (test_idx != cur_u_r) && adj_rd_row[test_idx] && !visited_r[test_idx];
  assign push_ent   = '{u: cur_u_r, next_v: cur_v_r + CNT_W'(1)};
  assign out_take   = out_valid_r && !out_stall;

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    root_nxt       = root_r;
    done_nxt       = done_r;
    cur_u_nxt      = cur_u_r;
    cur_v_nxt      = cur_v_r;
    sp_nxt         = sp_r;
    visited_nxt    = visited_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    push_en        = 1'b0;
    fin_en         = 1'b0;
    word_load      = 1'b0;
    word_idx       = '0;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          n_nxt       = ctl.count;
          root_nxt    = '0;
          done_nxt    = '0;
          visited_nxt = '0;
          state_nxt   = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_r == n_r) begin
          // Every vertex has finished; the last one to finish goes out first.
          emit_idx_nxt   = VIDX_W'(n_r - CNT_W'(1));
          word_load      = 1'b1;
          word_idx       = VIDX_W'(n_r - CNT_W'(1));
          out_last_nxt   = (n_r == CNT_W'(1));
          out_valid_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else if (visited_r[root_r[VIDX_W-1:0]]) begin
          root_nxt = root_r + CNT_W'(1);
        end else begin
          visited_nxt[root_r[VIDX_W-1:0]] = 1'b1;
          cur_u_nxt = root_r[VIDX_W-1:0];
          cur_v_nxt = '0;
          sp_nxt    = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cur_v_r >= n_r) begin
          // Neighbors exhausted: the vertex finishes and its parent resumes.
          fin_en   = 1'b1;
          done_nxt = done_r + CNT_W'(1);
          if (sp_r == '0) begin
            root_nxt  = root_r + CNT_W'(1);
            state_nxt = S_ROOT;
          end else begin
            cur_u_nxt = below_r.u;
            cur_v_nxt = below_r.next_v;
            sp_nxt    = sp_r - VIDX_W'(1);
          end
        end else if (hit) begin
          push_en               = 1'b1;
          visited_nxt[test_idx] = 1'b1;
          sp_nxt                = sp_r + VIDX_W'(1);
          cur_u_nxt             = test_idx;
          cur_v_nxt             = '0;
        end else begin
          cur_v_nxt = cur_v_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_take) begin
          if (emit_idx_r == '0) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            emit_idx_nxt   = emit_idx_r - VIDX_W'(1);
            word_load      = 1'b1;
            word_idx       = emit_idx_r - VIDX_W'(1);
            out_last_nxt   = (emit_idx_r == VIDX_W'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      done_r      <= '0;
      root_r      <= '0;
      visited_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      done_r      <= done_nxt;
      root_r      <= root_nxt;
      visited_r   <= visited_nxt;
    end
  end

  // below_r always holds the parent frame under the current vertex; a push
  // forwards the new frame, otherwise it is read from the entry below the next stack pointer.
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    cur_u_r      <= cur_u_nxt;
    cur_v_r      <= cur_v_nxt;
    emit_idx_r   <= emit_idx_nxt;
    out_last_r   <= out_last_nxt;
    if (word_load) begin
      out_vertex_r <= {1'b0, finish_r[word_idx]} + CNT_W'(1);
    end
    if (push_en) begin
      stack_r[sp_r] <= push_ent;
      below_r       <= push_ent;
    end else begin
      below_r <= stack_r[sp_nxt - VIDX_W'(1)];
    end
    if (fin_en) begin
      finish_r[done_r[VIDX_W-1:0]] <= cur_u_r;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> state_r == S_IDLE)
    else $error("sort started while engine busy");

  a_all_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && root_r == n_r) |-> done_r == n_r)
    else $error("search ended without every vertex finishing");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> cur_v_r <= n_r)
    else $error("neighbor scan ran past the vertex count");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_take && out_last_r) |=> state_r == S_IDLE && !out_valid_r)
    else $error("output continued after the last word");

endmodule

// File: rtl/dfs_topological_sort.sv
// Rows load one word per cycle while the input is not stalled; after the final row
// the search runs one neighbor test per cycle, then n words leave at one per
// cycle when the output is not stalled.
// Throughput is set by the single neighbor-test step of the search engine; input
// is stalled from the final row until the last output word is taken.
// Reset (rst_n, synchronous, active low) sets the vertex count to 16, row 0 next.
// ----------------------------------------------------------------------------
// dfs_topological_sort: depth-first topological sort of a small digraph
// Collects one adjacency row per input word. Once the row of the last vertex
// in use arrives, a depth-first search runs over the stored matrix and the
// vertices leave, 1-based, in reverse order of finishing; the final word is
// flagged. Cyclic graphs still produce the DFS order without any error flag.
// ----------------------------------------------------------------------------
module dfs_topological_sort
  import dts_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // Row input channel
  input  logic in_valid,
  output logic in_stall,
  input  row_t in_row_bits,
  // Result channel
  output logic out_valid,
  input  logic out_stall,
  output cnt_t out_vertex,
  output logic out_last,
  // Vertex count register
  input  logic cfg_valid,
  output logic cfg_ready,
  input  cnt_t cfg_vertex_count
);

  // Rows actually stored; the row store never exceeds the hardware ceiling.
  localparam int HARD = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;
  localparam int AW   = (HARD > 1) ? $clog2(HARD) : 1;

  cnt_t     vcount_r;
  cnt_t     rows_loaded_r;
  cnt_t     n_eff;
  logic     in_take;
  logic     last_row;
  logic     busy;
  vidx_t    adj_rd_idx;
  row_t     adj_rd_row;
  dts_ctl_t ctl;

  // The register accepts a write at any time; software must write it only while
  // the block is idle. A write also restarts loading at row 0.
  assign cfg_ready = 1'b1;

  // Effective vertex count: zero behaves as one, and anything above the
  // ceiling is clamped to it.
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (vcount_r > CNT_W'(HARD)) begin
      n_eff = CNT_W'(HARD);
    end else begin
      n_eff = vcount_r;
    end
  end

  // Input is held off for the whole search and output phase.
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign last_row = (rows_loaded_r + CNT_W'(1)) >= n_eff;

  assign ctl.start = in_take && last_row;
  assign ctl.count = n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r      <= CNT_W'(ROW_LIMIT);
      rows_loaded_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vcount_r      <= cfg_vertex_count;
      rows_loaded_r <= '0;
    end else if (in_take) begin
      rows_loaded_r <= last_row ? '0 : rows_loaded_r + CNT_W'(1);
    end
  end

  // Bits above the vertex count are stored as given; the search never tests
  // columns at or beyond the count, so they have no effect.
  dts_adj #(
    .HARD_ROWS (HARD)
  ) u_adj (
    .clk     (clk),
    .wr_en   (in_take),
    .wr_addr (rows_loaded_r[AW-1:0]),
    .wr_row  (in_row_bits),
    .rd_addr (adj_rd_idx[AW-1:0]),
    .rd_row  (adj_rd_row)
  );

  dts_dfs u_dfs (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .busy       (busy),
    .adj_rd_idx (adj_rd_idx),
    .adj_rd_row (adj_rd_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_vertex (out_vertex),
    .out_last   (out_last)
  );

endmodule
